FILE: hw/rtl/wsg_pkg.sv
package wsg_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_INCOMING = 2'd1,
    CMD_OUTGOING = 2'd2
  } cmd_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_CONN_TRUE  = 2'd1,
    KIND_CONN_FALSE = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SEQ_LENGTH = 2'd0,
    REG_SEQ_LOW    = 2'd1,
    REG_SEQ_HIGH   = 2'd2
  } cfg_reg_e;

  // Work handed from the front to the back, one entry per accepted item that
  // yields results.
  typedef enum logic [1:0] {
    JOB_DATA           = 2'd0,
    JOB_CONN_TRUE      = 2'd1,
    JOB_CONN_TRUE_DATA = 2'd2,
    JOB_CONN_FALSE     = 2'd3
  } job_e;

  typedef struct packed {
    job_e       job;
    logic [7:0] data_byte;
  } job_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       connect_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

endpackage

FILE: hw/rtl/wsg_front.sv
module wsg_front
  import wsg_pkg::*;
#(
  parameter int MAX_SEQ_BYTES   = 16,
  parameter int MAX_CONNECTIONS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        full,
  output logic        push,
  output job_t        push_job
);

  localparam logic [4:0] LenCap  = 5'(MAX_SEQ_BYTES);
  localparam int         CapInt  = (MAX_CONNECTIONS > 255) ? 255 : MAX_CONNECTIONS;
  localparam logic [7:0] CountCap = 8'(CapInt);

  logic [4:0]   seq_length;
  logic [63:0]  seq_low;
  logic [63:0]  seq_high;

  logic         waiting, waiting_next;
  logic [4:0]   match_position, match_position_next;
  logic         connect_was_sent, connect_was_sent_next;
  logic [7:0]   connection_count, connection_count_next;

  logic         accept;
  logic [4:0]   eff_len;
  logic [127:0] seq_all;
  logic [7:0]   seq_byte;
  logic [4:0]   pos_inc;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign eff_len  = (seq_length > LenCap) ? LenCap : seq_length;
  assign seq_all  = {seq_high, seq_low};
  assign seq_byte = seq_all[match_position[3:0]*8 +: 8];
  assign pos_inc  = match_position + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= '0;
      seq_low    <= '0;
      seq_high   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEQ_LENGTH: seq_length <= cfg_data[4:0];
        REG_SEQ_LOW:    seq_low    <= cfg_data;
        REG_SEQ_HIGH:   seq_high   <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    waiting_next          = waiting;
    match_position_next   = match_position;
    connect_was_sent_next = connect_was_sent;
    connection_count_next = connection_count;
    push                  = 1'b0;
    push_job.job          = JOB_DATA;
    push_job.data_byte    = in_item.data_byte;
    if (accept) begin
      case (in_item.command)
        CMD_DATA: begin
          if (!waiting) begin
            push         = 1'b1;
            push_job.job = JOB_DATA;
          end else if (match_position >= eff_len) begin
            // sequence already complete: announce, then pass this byte
            waiting_next          = 1'b0;
            connect_was_sent_next = 1'b1;
            push                  = 1'b1;
            push_job.job          = JOB_CONN_TRUE_DATA;
          end else if (seq_byte != in_item.data_byte) begin
            match_position_next = '0;
          end else begin
            match_position_next = pos_inc;
            if (pos_inc >= eff_len) begin
              waiting_next          = 1'b0;
              connect_was_sent_next = 1'b1;
              push                  = 1'b1;
              push_job.job          = JOB_CONN_TRUE;
            end
          end
        end
        CMD_INCOMING: begin
          if (!in_item.connect_value) begin
            if (connect_was_sent) begin
              connect_was_sent_next = 1'b0;
              push                  = 1'b1;
              push_job.job          = JOB_CONN_FALSE;
            end
            waiting_next        = 1'b1;
            match_position_next = '0;
          end
        end
        CMD_OUTGOING: begin
          if (in_item.connect_value) begin
            if (connection_count < CountCap) begin
              connection_count_next = connection_count + 8'd1;
            end
          end else begin
            if (connection_count > 8'd1 || connection_count == 8'd0) begin
              connection_count_next = (connection_count == 8'd0) ? 8'd0
                                      : connection_count - 8'd1;
            end else begin
              connection_count_next = 8'd0;
            end
            if (connection_count_next == 8'd0) begin
              waiting_next        = 1'b1;
              match_position_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting          <= 1'b1;
      match_position   <= '0;
      connect_was_sent <= 1'b0;
      connection_count <= '0;
    end else begin
      waiting          <= waiting_next;
      match_position   <= match_position_next;
      connect_was_sent <= connect_was_sent_next;
      connection_count <= connection_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_open_means_sent: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> connect_was_sent) else $error("gate open without connect sent");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    connection_count <= CountCap) else $error("connection count above cap");
`endif

endmodule

FILE: hw/rtl/wsg_queue.sv
module wsg_queue
  import wsg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t             entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QueueDepth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + QCntW'(push) - QCntW'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/wsg_back.sv
module wsg_back
  import wsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      load;
  logic      phase;
  logic      second_beat_due;
  out_item_t beat;

  assign load            = !out_valid || out_ready;
  assign second_beat_due = (head.job == JOB_CONN_TRUE_DATA) && !phase;
  assign pop             = load && !empty && !second_beat_due;

  always_comb begin
    beat.kind     = KIND_DATA;
    beat.out_byte = head.data_byte;
    beat.last     = 1'b1;
    case (head.job)
      JOB_DATA: ;
      JOB_CONN_TRUE: begin
        beat.kind     = KIND_CONN_TRUE;
        beat.out_byte = '0;
      end
      JOB_CONN_TRUE_DATA: begin
        if (!phase) begin
          beat.kind     = KIND_CONN_TRUE;
          beat.out_byte = '0;
          beat.last     = 1'b0;
        end
      end
      JOB_CONN_FALSE: begin
        beat.kind     = KIND_CONN_FALSE;
        beat.out_byte = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_item <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        phase <= second_beat_due;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!empty && head.job == JOB_CONN_TRUE_DATA))
    else $error("second beat pending without two-beat job");
  a_not_last_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last) |-> (out_item.kind == KIND_CONN_TRUE))
    else $error("non-final result is not connect-true");
`endif

endmodule

FILE: hw/rtl/wake_sequence_connect_gate.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_item   (command, data_byte, connect_value)
// out       output     out_valid/out_ready  out_item  (kind, out_byte, last)
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle while the four-entry job queue has room; its first result
// is written to the queue, then to the output register, where it becomes valid.
// Results leave one per cycle while out_ready is high, so a byte that completes an empty
// or shortened sequence gives two results in turn (connect-true, then the byte).
// rst is synchronous, active high: gate waiting, position and counters clear.
// A stalled output backs up the queue; once it is full every request stalls.
module wake_sequence_connect_gate
  import wsg_pkg::*;
#(
  parameter int MAX_SEQ_BYTES   = 16,
  parameter int MAX_CONNECTIONS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic empty;
  job_t head;

  // Configuration must be written only while idle (unchecked by the block), so take every request at once.
  assign cfg_ready = 1'b1;

  // Front: hold the match position and connect state, classify each request
  // into a job for the back, drop bytes while the gate is closed.
  wsg_front #(
    .MAX_SEQ_BYTES  (MAX_SEQ_BYTES),
    .MAX_CONNECTIONS(MAX_CONNECTIONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  // Queue: decouple classification from result delivery.
  wsg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  // Back: expand each job into one or two results in the output register.
  wsg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: dv/wake_sequence_connect_gate_tb.sv
`timescale 1ns / 1ps

module wake_sequence_connect_gate_tb;
  import wsg_pkg::*;

  // Codes the package leaves unnamed: the spare command and the spare register slot
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam int SEQ_MAX   = 16;   // longest wake sequence the gate honors
  localparam int CONN_CAP  = 255;  // connection counter ceiling
  localparam int PHASES    = 10;
  localparam int SETTLE    = 8;    // drain margin: queue write and output register plus queue depth
  localparam int LONG_HOLD = 400;  // output stall long enough to back up the queue

  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] value;
  } reg_write_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  wake_sequence_connect_gate dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Gate state as the predictor sees it, updated at each accepted request or register write
  logic [4:0]  seq_len_r    = '0;
  logic [63:0] seq_lo_r     = '0;
  logic [63:0] seq_hi_r     = '0;
  bit          gate_waiting = 1'b1;
  logic [4:0]  match_pos    = '0;
  bit          connect_sent = 1'b0;
  logic [7:0]  conn_count   = '0;

  // Register values the stimulus has asked for, used to build wake sequences
  logic [4:0]  plan_len = '0;
  logic [63:0] plan_lo  = '0;
  logic [63:0] plan_hi  = '0;

  in_item_t   queued_items[$];   // requests waiting for the driver
  reg_write_t queued_writes[$];  // register writes waiting for the config driver
  out_item_t  due_results[$];    // results the gate still owes, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;
  int hold_requests  = 0;  // bumped by the stimulus to start a long hold
  int holds_started  = 0;
  int phase_items    = 0;
  int errors         = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int writes_done    = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] seq_byte_of(logic [63:0] lo, logic [63:0] hi, int i);
    return (i < 8) ? lo[i*8 +: 8] : hi[(i-8)*8 +: 8];
  endfunction

  // Oversized lengths fall back to the full sixteen bytes
  function automatic int clamp_len(logic [4:0] n);
    return (n > SEQ_MAX) ? SEQ_MAX : int'(n);
  endfunction

  // Advance the gate by one request and queue the results it owes
  function automatic void gate_step(in_item_t it);
    int len;
    len = clamp_len(seq_len_r);
    case (it.command)
      CMD_DATA: begin
        if (!gate_waiting) begin
          due_results.push_back('{kind: KIND_DATA, out_byte: it.data_byte, last: 1'b1});
        end else if (match_pos >= len) begin
          // empty sequence, or length dropped to or below the position: connect, then pass
          gate_waiting = 1'b0;
          connect_sent = 1'b1;
          due_results.push_back('{kind: KIND_CONN_TRUE, out_byte: 8'h00, last: 1'b0});
          due_results.push_back('{kind: KIND_DATA, out_byte: it.data_byte, last: 1'b1});
        end else if (seq_byte_of(seq_lo_r, seq_hi_r, int'(match_pos[3:0])) != it.data_byte)
        begin
          // drop back to the start without testing this byte again
          match_pos = '0;
        end else begin
          match_pos = match_pos + 5'd1;
          if (match_pos >= len) begin
            gate_waiting = 1'b0;
            connect_sent = 1'b1;
            due_results.push_back('{kind: KIND_CONN_TRUE, out_byte: 8'h00, last: 1'b1});
          end
        end
      end
      CMD_INCOMING: begin
        if (!it.connect_value) begin
          if (connect_sent) begin
            connect_sent = 1'b0;
            due_results.push_back('{kind: KIND_CONN_FALSE, out_byte: 8'h00, last: 1'b1});
          end
          gate_waiting = 1'b1;
          match_pos    = '0;
        end
      end
      CMD_OUTGOING: begin
        if (it.connect_value) begin
          if (conn_count < CONN_CAP) conn_count = conn_count + 8'd1;
        end else begin
          if (conn_count != 0) conn_count = conn_count - 8'd1;
          if (conn_count == 0) begin
            gate_waiting = 1'b1;
            match_pos    = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 100) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Request driver: predict on acceptance, then offer the next request or idle.
  // Hold valid and payload steady until the request is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        gate_step(in_item);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= queued_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; the predictor copy follows each accepted write
  always @(posedge clk) begin : reg_driver
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEQ_LENGTH: seq_len_r = cfg_data[4:0];
          REG_SEQ_LOW:    seq_lo_r  = cfg_data;
          REG_SEQ_HIGH:   seq_hi_r  = cfg_data;
          default: ;
        endcase
        writes_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (queued_writes.size() != 0) begin
          w = queued_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.index;
          cfg_data  <= w.value;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off: start one per stimulus request, count it down here
  always @(posedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started <= hold_requests;
      stall_left    <= LONG_HOLD;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor: compare each taken result against the oldest one owed,
  // then pick the next ready level
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                    out_item.kind, out_item.out_byte, out_item.last));
        end else begin
          want = due_results.pop_front();
          if (out_item.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, want.kind));
          if (out_item.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      out_item.out_byte, want.out_byte));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_item.last, want.last));
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_item(logic [1:0] cmd, logic [7:0] b, logic v);
    queued_items.push_back('{command: cmd, data_byte: b, connect_value: v});
    if (cmd != CMD_UNUSED) phase_items++;
  endtask

  // Hold off until every request is taken and every owed result has come,
  // then let in-flight requests that owe nothing clear the pipe
  task automatic settle();
    while (queued_items.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    queued_writes.push_back('{index: idx, value: value});
    case (idx)
      REG_SEQ_LENGTH: plan_len = value[4:0];
      REG_SEQ_LOW:    plan_lo  = value;
      REG_SEQ_HIGH:   plan_hi  = value;
      default: ;
    endcase
    while (queued_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  // One burst of traffic: mostly clean wake-up sequences with payload behind
  // them, some broken ones, connect events and raw noise
  task automatic send_episode();
    int pick, n, len, i;
    logic [7:0] b;
    len  = clamp_len(plan_len);
    pick = $urandom_range(99);
    if (pick < 55) begin
      queue_item(CMD_INCOMING, 8'($urandom), 1'b0);  // restart the wait from position zero
      n = $urandom_range(2);
      repeat (n) queue_item(CMD_DATA, 8'($urandom), 1'($urandom));
      for (i = 0; i < len; i++)
        queue_item(CMD_DATA, seq_byte_of(plan_lo, plan_hi, i), 1'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) queue_item(CMD_DATA, 8'($urandom), 1'($urandom));
    end else if (pick < 70) begin
      queue_item(CMD_INCOMING, 8'($urandom), 1'b0);
      if (len > 0) begin
        n = $urandom_range(len - 1);
        for (i = 0; i < n; i++)
          queue_item(CMD_DATA, seq_byte_of(plan_lo, plan_hi, i), 1'($urandom));
        b = seq_byte_of(plan_lo, plan_hi, n) ^ 8'($urandom_range(1, 255));
        queue_item(CMD_DATA, b, 1'($urandom));
      end
      repeat (2) queue_item(CMD_DATA, 8'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_item($urandom_range(1) ? CMD_INCOMING : CMD_OUTGOING, 8'($urandom),
                            1'($urandom));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) queue_item(2'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int phase, target;
    logic [63:0] lo, hi;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty sequence at reset, pass-through, connect filtering,
    // unused command, counter reaching zero
    queue_item(CMD_DATA, 8'h00, 1'b0);
    queue_item(CMD_DATA, 8'hFF, 1'b1);
    queue_item(CMD_INCOMING, 8'h00, 1'b1);
    queue_item(CMD_DATA, 8'h80, 1'b0);
    queue_item(CMD_INCOMING, 8'hFF, 1'b0);
    queue_item(CMD_INCOMING, 8'h00, 1'b0);
    queue_item(CMD_UNUSED, 8'hAA, 1'b1);
    queue_item(CMD_OUTGOING, 8'h00, 1'b0);
    queue_item(CMD_OUTGOING, 8'h55, 1'b1);
    queue_item(CMD_DATA, 8'h01, 1'b1);
    queue_item(CMD_OUTGOING, 8'h00, 1'b0);
    queue_item(CMD_DATA, 8'h7F, 1'b0);
    settle();

    // Three-byte sequence; a repeated first byte drops the match back to the start
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SEQ_LOW, 64'h0000_0000_00FF_A55A);
    write_reg(REG_SEQ_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SEQ_LENGTH, 64'd3);
    queue_item(CMD_INCOMING, 8'h00, 1'b0);
    queue_item(CMD_DATA, 8'h5A, 1'b0);
    queue_item(CMD_DATA, 8'h5A, 1'b0);
    queue_item(CMD_DATA, 8'hA5, 1'b0);
    queue_item(CMD_DATA, 8'h5A, 1'b1);
    queue_item(CMD_DATA, 8'hA5, 1'b1);
    queue_item(CMD_DATA, 8'hFF, 1'b0);
    queue_item(CMD_DATA, 8'h80, 1'b0);
    queue_item(CMD_INCOMING, 8'h00, 1'b0);
    queue_item(CMD_DATA, 8'h5A, 1'b0);
    queue_item(CMD_DATA, 8'hA5, 1'b0);
    settle();
    // Shrink the length under the partial match: next byte connects and passes
    write_reg(REG_SEQ_LENGTH, 64'd1);
    queue_item(CMD_DATA, 8'h33, 1'b1);
    settle();

    // Random phases, each with its own sequence and idle pattern
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase

      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (phase == 4) begin
        lo = '0;
        hi = '0;
      end else if (phase == 3 || phase == 8) begin
        lo = '1;
        hi = '1;
      end
      write_reg(REG_NONE, {$urandom, $urandom});
      write_reg(REG_SEQ_LOW, lo);
      write_reg(REG_SEQ_HIGH, hi);
      case (phase % 5)
        0: write_reg(REG_SEQ_LENGTH, 64'(SEQ_MAX));
        1: write_reg(REG_SEQ_LENGTH, 64'd0);
        2: write_reg(REG_SEQ_LENGTH, 64'd31);
        3: write_reg(REG_SEQ_LENGTH, 64'd1);
        default: write_reg(REG_SEQ_LENGTH, 64'($urandom_range(2, 15)));
      endcase

      phase_items = 0;
      target = 70;
      if (phase == 6) begin
        // Drive the counter past its ceiling, then back through zero
        repeat (CONN_CAP + 5) queue_item(CMD_OUTGOING, 8'($urandom), 1'b1);
        repeat (CONN_CAP + 3) queue_item(CMD_OUTGOING, 8'($urandom), 1'b0);
        target = phase_items + 40;
      end
      if (phase == 4) hold_requests++;  // back up the queue while requests keep coming
      while (phase_items < target) begin
        send_episode();
        if (phase == 8 && phase_items >= 35 && phase_items < 45) begin
          settle();  // pause the sender until nothing is owed
          phase_items = 45;
        end
      end
      settle();
    end

    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    $display("summary: %0d requests taken, %0d results checked, %0d register writes, %0d phases",
             items_accepted, results_checked, writes_done, PHASES + 2);
    $display("covered: empty, full and oversized sequences, broken matches, connect filtering, %s",
             "counter saturation, four idle patterns and a long output stall");
    if (errors == 0) begin
      $display("wake_sequence_connect_gate_tb: done, clean");
    end else begin
      $display("wake_sequence_connect_gate_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: %0d requests queued, %0d results owed", queued_items.size(),
             due_results.size());
    $display("wake_sequence_connect_gate_tb: done, errors");
    $finish;
  end

endmodule
